/* design/crc16_command_frame_encoder_top_macros.svh */
// Assertion macros used by the frame encoder serializer.
`ifndef CRC16_COMMAND_FRAME_ENCODER_TOP_MACROS_SVH
`define CRC16_COMMAND_FRAME_ENCODER_TOP_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define CFE_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define CFE_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define CFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/crc16cfe_pkg.sv */
// Shared types, constants and the CRC byte update for the frame encoder.
package crc16cfe_pkg;

   localparam int MaxOut  = 6;
   localparam int OutIdxW = $clog2(MaxOut);

   localparam logic [7:0]  SofA      = 8'hAA;
   localparam logic [7:0]  SofB      = 8'hFE;
   localparam logic [15:0] CrcInit   = 16'hFFFF;
   localparam logic [16:0] HdrItemsA = 17'd4;
   localparam logic [16:0] HdrItemsB = 17'd1;
   localparam logic [16:0] LenPosA   = HdrItemsA - 17'd1;

   localparam logic FmtA = 1'b0;
   localparam logic FmtB = 1'b1;

   // One item's worth of output words, packed from entry 0 upward.
   typedef struct packed {
      logic [MaxOut-1:0][7:0] words;
      logic [OutIdxW-1:0]     count;
      logic                   close;
   } bundle_type;

   // CRC-16/CCITT-FALSE update by one byte (poly 0x1021, MSB first).
   function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = {crc[7:0], crc[15:8]};
      c = c ^ {8'h00, b};
      c = c ^ {12'h000, c[7:4]};
      c = c ^ {c[3:0], 12'h000};
      c = c ^ {3'b000, c[7:0], 5'b00000};
      return c;
   endfunction

endpackage

/* design/crc16cfe_framer.sv */
// Input register, frame state and single-pass build of one item's output words.
module crc16cfe_framer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic [15:0]             req_payload_length,
   input  logic                    bundle_load,
   output logic                    bundle_valid,
   output crc16cfe_pkg::bundle_type bundle
);
   import crc16cfe_pkg::*;

   logic        format_ff;
   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic [15:0] in_len_ff;
   logic [15:0] crc_ff,   crc_in;
   logic [16:0] seen_ff,  seen_in;
   logic [15:0] len_ff,   len_in;
   logic        frame_ff, frame_in;

   logic                take;
   logic [15:0]         crc_cur;
   logic [16:0]         seen_cur;
   logic [15:0]         len_cur;
   logic [15:0]         crc_run;
   logic [15:0]         len_b;
   logic [16:0]         count;
   logic [16:0]         hdr;
   logic                first;
   logic [OutIdxW-1:0]  n;

   // Move the held item into the serializer when it has room.
   assign take         = in_valid_ff && bundle_load;
   assign req_stall    = in_valid_ff && !bundle_load;
   assign bundle_valid = in_valid_ff;

   // Hold the format register.
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FmtA;
      end else if (csr_wr_en) begin
         format_ff <= csr_wr_data;
      end
   end

   // Capture the incoming word.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_len_ff  <= req_payload_length;
      end
   end

   // Build the output words and the next frame state for the held item.
   always_comb begin
      crc_cur  = frame_ff ? crc_ff  : CrcInit;
      seen_cur = frame_ff ? seen_ff : 17'd0;
      len_cur  = frame_ff ? len_ff  : in_len_ff;
      first    = (seen_cur == 17'd0);
      hdr      = (format_ff == FmtB) ? HdrItemsB : HdrItemsA;
      len_b    = len_cur + 16'd2;
      crc_run  = crc_cur;
      bundle   = '0;
      n        = '0;

      // Open with the start-of-frame word.
      if (first) begin
         bundle.words[n] = (format_ff == FmtB) ? SofB : SofA;
         crc_run         = crc_update(crc_run, bundle.words[n]);
         n               = n + 1'b1;
      end

      // Pass the command byte itself.
      bundle.words[n] = in_data_ff;
      crc_run         = crc_update(crc_run, in_data_ff);
      n               = n + 1'b1;

      // Insert the length field at the format's own header position.
      if ((format_ff == FmtB) && first) begin
         bundle.words[n] = len_b[7:0];
         crc_run         = crc_update(crc_run, len_b[7:0]);
         n               = n + 1'b1;
         bundle.words[n] = len_b[15:8];
         crc_run         = crc_update(crc_run, len_b[15:8]);
         n               = n + 1'b1;
      end else if ((format_ff == FmtA) && (seen_cur == LenPosA)) begin
         bundle.words[n] = len_cur[7:0];
         crc_run         = crc_update(crc_run, len_cur[7:0]);
         n               = n + 1'b1;
         bundle.words[n] = len_cur[15:8];
         crc_run         = crc_update(crc_run, len_cur[15:8]);
         n               = n + 1'b1;
      end

      // Close the frame once header and payload are all taken.
      count        = seen_cur + 17'd1;
      bundle.close = ({1'b0, count} >= ({2'b00, len_cur} + {1'b0, hdr}));
      if (bundle.close) begin
         bundle.words[n] = crc_run[7:0];
         n               = n + 1'b1;
         bundle.words[n] = crc_run[15:8];
         n               = n + 1'b1;
      end
      bundle.count = n;

      if (bundle.close) begin
         crc_in   = CrcInit;
         seen_in  = 17'd0;
         len_in   = 16'd0;
         frame_in = 1'b0;
      end else begin
         crc_in   = crc_run;
         seen_in  = count;
         len_in   = len_cur;
         frame_in = 1'b1;
      end
   end

   // Advance the frame state as each item leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CrcInit;
         seen_ff  <= 17'd0;
         len_ff   <= 16'd0;
         frame_ff <= 1'b0;
      end else if (take) begin
         crc_ff   <= crc_in;
         seen_ff  <= seen_in;
         len_ff   <= len_in;
         frame_ff <= frame_in;
      end
   end

endmodule

/* design/crc16cfe_serializer.sv */
// Result register that hands out one item's words one per cycle while rsp_stall is low.
module crc16cfe_serializer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     bundle_valid,
   input  crc16cfe_pkg::bundle_type bundle,
   output logic                     bundle_load,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_last,
   output logic                     rsp_frame_end
);
   import crc16cfe_pkg::*;

   logic                   full_ff;
   logic [MaxOut-1:0][7:0] words_ff;
   logic [OutIdxW-1:0]     count_ff;
   logic [OutIdxW-1:0]     pos_ff;
   logic                   close_ff;
   logic                   last;
   logic                   send;

   // Present the current word.
   assign last          = (pos_ff == (count_ff - 1'b1));
   assign send          = full_ff && !rsp_stall;
   assign rsp_valid     = full_ff;
   assign rsp_out_byte  = words_ff[pos_ff];
   assign rsp_run_last  = last;
   assign rsp_frame_end = close_ff && last;

   // Take a new bundle when empty or while the last word goes out.
   assign bundle_load = !full_ff || (send && last);

   // Load, advance or drain the word list.
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (bundle_load && bundle_valid) begin
         full_ff <= 1'b1;
         pos_ff  <= '0;
      end else if (send && last) begin
         full_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (send) begin
         pos_ff  <= pos_ff + 1'b1;
      end
      if (bundle_load && bundle_valid) begin
         words_ff <= bundle.words;
         count_ff <= bundle.count;
         close_ff <= bundle.close;
      end
   end

`include "crc16_command_frame_encoder_top_macros.svh"

   `CFE_ASSERT_IMPLY(a_pos_in_range, full_ff, (count_ff != '0) && (pos_ff < count_ff), "word position past item count")
   `CFE_ASSERT_IMPLY(a_close_has_crc, full_ff && close_ff, count_ff >= 3'd2, "closing item lacks CRC words")
   `CFE_ASSERT_NEXT(a_step, send && !last && !(bundle_load && bundle_valid), pos_ff == $past(pos_ff) + 1'b1, "word position did not advance")
   `CFE_ASSERT_ALWAYS(a_load_only_idle, !(bundle_load && full_ff) || (send && last), "bundle loaded over live words")

endmodule

/* design/crc16_command_frame_encoder_top.sv */
// Top level of the CRC-16 command frame encoder.
// Frames a stream of command bytes: one input word yields 1 to 6 output words (start
// byte, header, length field, payload byte, CRC trailer), with the CRC-16/CCITT-FALSE
// appended low byte first and frame_end on its high byte. Output words leave one per
// cycle through the single output byte port while rsp_stall is low; payload words that
// yield one output word stream at one per cycle. An accepted input word passes the
// framer's input register, then the serializer's result register. The user must write
// frame_format only while the encoder is idle; the block itself does not enforce this.
module crc16_command_frame_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_payload_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_end
);
   import crc16cfe_pkg::*;

   bundle_type bundle;
   logic       bundle_valid;
   logic       bundle_load;

   // Build each item's words and frame state.
   crc16cfe_framer u_framer (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_payload_length (req_payload_length),
      .bundle_load        (bundle_load),
      .bundle_valid       (bundle_valid),
      .bundle             (bundle)
   );

   // Hand out words one per cycle while rsp_stall is low.
   crc16cfe_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .bundle_valid  (bundle_valid),
      .bundle        (bundle),
      .bundle_load   (bundle_load),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
